// File: src/cba_pkg.sv
// Package: shared types and constants for the chunked bump allocator.
`timescale 1ns / 1ps
package cba_pkg;

    localparam int unsigned SIZE_W = 25;
    localparam int unsigned ADDR_W = 24;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned STAT_W = 2;

    localparam logic [SIZE_W-1:0] DEFAULT_CHUNK   = 25'd1048576;
    localparam logic [SIZE_W-1:0] DEFAULT_DISCARD = 25'd64;

    localparam logic [0:0] ACT_ALLOC = 1'b0;
    localparam logic [0:0] ACT_RESET = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MEM_FULL  = 2'd2;

    localparam logic [0:0] CFG_CHUNK   = 1'b0;
    localparam logic [0:0] CFG_DISCARD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RST,
        S_SEARCH,
        S_CHECK,
        S_NEW,
        S_SERVE,
        S_REMOVE,
        S_STATS,
        S_OUT
    } cba_state_t;

    typedef struct packed {
        logic start;
        logic rst_step;
        logic search_step;
        logic new_chunk;
        logic serve;
        logic rewind;
        logic remove_step;
        logic stats_step;
        logic set_table_full;
        logic set_mem_full;
        logic load_out;
    } cba_cmd_t;

    typedef struct packed {
        logic is_reset;
        logic rst_done;
        logic search_done;
        logic fits;
        logic table_full;
        logic mem_full;
        logic need_remove;
        logic remove_done;
        logic stats_done;
    } cba_stat_t;

endpackage

// File: src/cba_ctrl.sv
// Controller: sequences reset, search, chunk creation, list removal and stats.
`timescale 1ns / 1ps
module cba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_free,
    input  cba_pkg::cba_stat_t  stat,
    output cba_pkg::cba_cmd_t   cmd,
    output logic                busy
);

    cba_pkg::cba_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cba_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cba_pkg::S_IDLE: begin
                if (in_fire) state_next = cba_pkg::S_CHECK;
            end
            cba_pkg::S_CHECK: begin
                state_next = stat.is_reset ? cba_pkg::S_RST : cba_pkg::S_SEARCH;
            end
            cba_pkg::S_RST: begin
                if (stat.rst_done) state_next = cba_pkg::S_STATS;
            end
            cba_pkg::S_SEARCH: begin
                if (stat.fits) state_next = cba_pkg::S_SERVE;
                else if (stat.search_done) begin
                    if (stat.table_full || stat.mem_full) state_next = cba_pkg::S_STATS;
                    else state_next = cba_pkg::S_NEW;
                end
            end
            cba_pkg::S_NEW: begin
                state_next = cba_pkg::S_SEARCH;
            end
            cba_pkg::S_SERVE: begin
                state_next = stat.need_remove ? cba_pkg::S_REMOVE : cba_pkg::S_STATS;
            end
            cba_pkg::S_REMOVE: begin
                if (stat.remove_done) state_next = cba_pkg::S_STATS;
            end
            cba_pkg::S_STATS: begin
                if (stat.stats_done) state_next = cba_pkg::S_OUT;
            end
            cba_pkg::S_OUT: begin
                if (out_free) state_next = cba_pkg::S_IDLE;
            end
            default: state_next = cba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            cba_pkg::S_IDLE: begin
                busy = 1'b0;
                cmd.start = in_fire;
            end
            cba_pkg::S_RST: cmd.rst_step = 1'b1;
            cba_pkg::S_SEARCH: begin
                cmd.search_step = !stat.fits && !stat.search_done;
                cmd.serve = stat.fits;
                cmd.set_table_full = !stat.fits && stat.search_done && stat.table_full;
                cmd.set_mem_full = !stat.fits && stat.search_done && !stat.table_full
                                   && stat.mem_full;
            end
            cba_pkg::S_NEW: cmd.new_chunk = 1'b1;
            cba_pkg::S_SERVE: cmd.rewind = !stat.need_remove;
            cba_pkg::S_REMOVE: cmd.remove_step = 1'b1;
            cba_pkg::S_STATS: cmd.stats_step = 1'b1;
            cba_pkg::S_OUT: cmd.load_out = out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// File: src/cba_dp.sv
// Datapath: chunk table, free list, counters and statistics accumulators.
`timescale 1ns / 1ps
module cba_dp #(
    parameter int unsigned MAX_CHUNKS = 16,
    parameter longint unsigned MEM_BYTES = 64'd16777216
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [cba_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       in_action,
    input  logic [cba_pkg::SIZE_W-1:0] in_request_bytes,
    input  cba_pkg::cba_cmd_t          cmd,
    output cba_pkg::cba_stat_t         stat,
    output logic [cba_pkg::ADDR_W-1:0] r_grant_address,
    output logic                       r_granted,
    output logic [cba_pkg::STAT_W-1:0] r_status,
    output logic [cba_pkg::SIZE_W-1:0] r_size_sum,
    output logic [cba_pkg::SIZE_W-1:0] r_spare_sum,
    output logic [cba_pkg::CNT_W-1:0]  r_chunk_total,
    output logic [cba_pkg::CNT_W-1:0]  r_chunk_free
);

    localparam int unsigned IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned TOP_W = $clog2(MEM_BYTES + 1);
    localparam int unsigned SW = cba_pkg::SIZE_W;
    localparam int unsigned TW = (TOP_W > SW ? TOP_W : SW) + 1;
    localparam logic [TW-1:0] MEM_LIMIT = TW'(MEM_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

    logic [cba_pkg::ADDR_W-1:0] base_mem [MAX_CHUNKS];
    logic [SW-1:0] len_mem  [MAX_CHUNKS];
    logic [SW-1:0] used_mem [MAX_CHUNKS];
    logic [IDX_W-1:0] order_mem [MAX_CHUNKS];

    logic [SW-1:0] chunk_cfg_reg, discard_cfg_reg;
    logic [CW-1:0] chunk_count_reg, free_count_reg;
    logic [TW-1:0] top_reg;
    logic action_reg;
    logic [SW-1:0] size_reg;
    logic [CW-1:0] pos_reg;
    logic [SW-1:0] new_used_reg;
    logic [SW-1:0] len_sel_reg;
    logic [SW-1:0] tot_reg, fre_reg;
    logic [cba_pkg::ADDR_W-1:0] addr_reg;
    logic granted_reg;
    logic [cba_pkg::STAT_W-1:0] status_reg;

    logic [SW-1:0] once, discard, new_len;
    logic [IDX_W-1:0] pos_idx, cur_c;
    logic [SW-1:0] rem;
    logic [TW-1:0] top_sum;

    assign once    = (chunk_cfg_reg == '0) ? cba_pkg::DEFAULT_CHUNK : chunk_cfg_reg;
    assign discard = (discard_cfg_reg == '0) ? cba_pkg::DEFAULT_DISCARD : discard_cfg_reg;
    assign new_len = (size_reg < once) ? once : size_reg;
    assign pos_idx = pos_reg[IDX_W-1:0];
    assign cur_c   = order_mem[pos_idx];
    assign rem     = len_mem[cur_c] - used_mem[cur_c];
    assign top_sum = top_reg + TW'(new_len);

    always_comb begin
        stat = '0;
        stat.is_reset    = action_reg;
        stat.rst_done    = (pos_reg + 1'b1 >= chunk_count_reg);
        stat.search_done = (pos_reg >= free_count_reg);
        stat.fits        = (pos_reg < free_count_reg) && (rem >= size_reg);
        stat.table_full  = (chunk_count_reg >= MAXC);
        stat.mem_full    = (top_sum > MEM_LIMIT);
        stat.need_remove = (len_sel_reg - new_used_reg) <= discard;
        stat.remove_done = (pos_reg + 1'b1 >= free_count_reg);
        stat.stats_done  = (pos_reg + 1'b1 >= chunk_count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_cfg_reg   <= cba_pkg::DEFAULT_CHUNK;
            discard_cfg_reg <= cba_pkg::DEFAULT_DISCARD;
            chunk_count_reg <= '0;
            free_count_reg  <= '0;
            top_reg         <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == cba_pkg::CFG_CHUNK) chunk_cfg_reg <= cfg_data;
                else discard_cfg_reg <= cfg_data;
            end
            if (cmd.rst_step) begin
                if (stat.rst_done) free_count_reg <= chunk_count_reg;
            end
            if (cmd.new_chunk) begin
                chunk_count_reg <= chunk_count_reg + 1'b1;
                free_count_reg  <= free_count_reg + 1'b1;
                top_reg         <= top_sum;
            end
            if (cmd.remove_step && stat.remove_done) free_count_reg <= free_count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            action_reg <= in_action;
            size_reg   <= in_request_bytes;
            pos_reg    <= '0;
            granted_reg <= 1'b0;
            status_reg <= cba_pkg::ST_OK;
            addr_reg   <= '0;
            tot_reg    <= '0;
            fre_reg    <= '0;
        end
        if (cmd.rst_step) begin
            if (chunk_count_reg != '0) begin
                used_mem[pos_idx]  <= '0;
                order_mem[pos_idx] <= pos_idx;
            end
            pos_reg <= stat.rst_done ? '0 : pos_reg + 1'b1;
        end
        if (cmd.search_step) pos_reg <= pos_reg + 1'b1;
        if (cmd.set_table_full) status_reg <= cba_pkg::ST_TABLE_FULL;
        if (cmd.set_mem_full) status_reg <= cba_pkg::ST_MEM_FULL;
        if ((cmd.set_table_full || cmd.set_mem_full)) pos_reg <= '0;
        if (cmd.new_chunk) begin
            base_mem[chunk_count_reg[IDX_W-1:0]] <= top_reg[cba_pkg::ADDR_W-1:0];
            len_mem[chunk_count_reg[IDX_W-1:0]]  <= new_len;
            used_mem[chunk_count_reg[IDX_W-1:0]] <= '0;
            for (int i = MAX_CHUNKS - 1; i > 0; i--) begin
                order_mem[i] <= order_mem[i-1];
            end
            order_mem[0] <= chunk_count_reg[IDX_W-1:0];
            pos_reg <= '0;
        end
        if (cmd.serve) begin
            addr_reg     <= base_mem[cur_c] + used_mem[cur_c][cba_pkg::ADDR_W-1:0];
            used_mem[cur_c] <= used_mem[cur_c] + size_reg;
            new_used_reg <= used_mem[cur_c] + size_reg;
            len_sel_reg  <= len_mem[cur_c];
            granted_reg  <= 1'b1;
        end
        if (cmd.rewind) pos_reg <= '0;
        if (cmd.remove_step) begin
            if (!stat.remove_done) begin
                order_mem[pos_idx] <= order_mem[IDX_W'(pos_reg + 1'b1)];
                pos_reg <= pos_reg + 1'b1;
            end else begin
                pos_reg <= '0;
            end
        end
        if (cmd.stats_step) begin
            if (chunk_count_reg != '0) begin
                tot_reg <= tot_reg + len_mem[pos_idx];
                fre_reg <= fre_reg + (len_mem[pos_idx] - used_mem[pos_idx]);
            end
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.load_out) begin
            r_grant_address <= addr_reg;
            r_granted       <= granted_reg;
            r_status        <= status_reg;
            r_size_sum      <= tot_reg;
            r_spare_sum     <= fre_reg;
            r_chunk_total   <= cba_pkg::CNT_W'(chunk_count_reg);
            r_chunk_free    <= cba_pkg::CNT_W'(free_count_reg);
        end
    end

endmodule

// File: src/chunked_bump_allocator.sv
// Top level: chunked bump allocator with first-fit free list search.
`timescale 1ns / 1ps
// One item is taken at a time; the search, list shift and statistics each visit one
// table entry per cycle. An allocate item searches the free list, makes a new chunk
// when none fits and searches again, and is refused when the table or memory is
// full; when the served chunk leaves the free list the shift visits each entry from
// its position to the end of the list. A reset item clears every chunk and refills
// the free list. Every item ends with a statistics pass over all chunks. The result
// sits in an output register: the next item is taken while it waits, and a new result
// is held back until the previous one is read.
module chunked_bump_allocator #(
    parameter int unsigned MAX_CHUNKS = 16,
    parameter longint unsigned MEM_BYTES = 64'd16777216
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // request_bytes[24:0], zero fill
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata   // grant_address, granted, status, chunk size sum,
                                  // spare byte sum, chunk_total, chunk_free, zero fill
);

    cba_pkg::cba_cmd_t  cmd;
    cba_pkg::cba_stat_t stat;
    logic busy, in_fire, out_free, valid_reg;
    logic [23:0] ga; logic gr; logic [1:0] st;
    logic [24:0] tb, fb; logic [4:0] ct, cf;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;

    cba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .busy(busy)
    );

    cba_dp #(.MAX_CHUNKS(MAX_CHUNKS), .MEM_BYTES(MEM_BYTES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_action(s_tuser), .in_request_bytes(s_tdata[24:0]),
        .cmd(cmd), .stat(stat), .r_grant_address(ga), .r_granted(gr), .r_status(st),
        .r_size_sum(tb), .r_spare_sum(fb), .r_chunk_total(ct), .r_chunk_free(cf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, cf, ct, fb, tb, st, gr, ga};

endmodule

// File: src/cba_checker.sv
// Checker: port-level properties of the allocator, bound to the top level.
`timescale 1ns / 1ps
module cba_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [87:0]  m_tdata
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accept while busy");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[24] |-> m_tdata[23:0] == 24'd0) else $error("addr not zero");

    a_status_ok_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[24] |-> m_tdata[26:25] == 2'd0) else $error("bad status");

    a_free_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[86:82] <= m_tdata[81:77]) else $error("free count");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("data moved");

endmodule

bind chunked_bump_allocator cba_checker u_cba_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// File: tb/tb_top.sv
// Testbench for the chunked bump allocator: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int NCH = 16;
    localparam longint MEMB = 64'd16777216;
    localparam longint LIMIT = 64'd2000000;

    typedef struct packed {
        logic [cba_pkg::CNT_W-1:0]  cfree;
        logic [cba_pkg::CNT_W-1:0]  ctotal;
        logic [cba_pkg::SIZE_W-1:0] freeb;
        logic [cba_pkg::SIZE_W-1:0] total;
        logic [cba_pkg::STAT_W-1:0] status;
        logic                       granted;
        logic [cba_pkg::ADDR_W-1:0] addr;
    } grant_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [24:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [87:0] m_tdata;

    chunked_bump_allocator dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    longint p_chunk, p_discard;
    longint c_base[NCH], c_len[NCH], c_used[NCH];
    int f_order[NCH];
    int c_count, f_count;
    longint mem_top;

    grant_t grants_due[$];
    int mismatches = 0;
    int items_sent = 0, grants_seen = 0, n_full = 0, n_exh = 0;
    bit quiet = 1'b0;
    longint cycles = 0;

    function automatic void list_drop(int pos);
        for (int i = pos; i + 1 < f_count; i++) f_order[i] = f_order[i+1];
        f_count--;
    endfunction

    function automatic bit serve_from(int pos, longint sz, longint disc, output longint a);
        int c;
        c = f_order[pos];
        a = 0;
        if (c_len[c] - c_used[c] < sz) return 1'b0;
        a = c_base[c] + c_used[c];
        c_used[c] += sz;
        if (c_len[c] - c_used[c] <= disc) list_drop(pos);
        return 1'b1;
    endfunction

    function automatic grant_t predict_grant(bit act, longint sz);
        grant_t g;
        longint once, disc, a, tot, fb, len;
        bit gr;
        logic [cba_pkg::STAT_W-1:0] st;
        once = p_chunk ? p_chunk : 64'd1048576;
        disc = p_discard ? p_discard : 64'd64;
        a = 0; tot = 0; fb = 0; gr = 0; st = cba_pkg::ST_OK;
        if (act == cba_pkg::ACT_RESET) begin
            for (int i = 0; i < c_count; i++) begin
                c_used[i] = 0;
                f_order[i] = i;
            end
            f_count = c_count;
        end else begin
            for (int i = 0; i < f_count; i++)
                if (serve_from(i, sz, disc, a)) begin
                    gr = 1;
                    break;
                end
            if (!gr) begin
                len = sz < once ? once : sz;
                if (c_count >= NCH) st = cba_pkg::ST_TABLE_FULL;
                else if (mem_top + len > MEMB) st = cba_pkg::ST_MEM_FULL;
                else begin
                    c_base[c_count] = mem_top;
                    c_len[c_count] = len;
                    c_used[c_count] = 0;
                    mem_top += len;
                    for (int i = f_count; i > 0; i--) f_order[i] = f_order[i-1];
                    f_order[0] = c_count;
                    c_count++;
                    f_count++;
                    gr = serve_from(0, sz, disc, a);
                end
            end
            if (!gr) a = 0;
        end
        for (int i = 0; i < c_count; i++) begin
            tot += c_len[i];
            fb += c_len[i] - c_used[i];
        end
        g.addr = a[cba_pkg::ADDR_W-1:0];
        g.granted = gr;
        g.status = st;
        g.total = tot[cba_pkg::SIZE_W-1:0];
        g.freeb = fb[cba_pkg::SIZE_W-1:0];
        g.ctotal = c_count[cba_pkg::CNT_W-1:0];
        g.cfree = f_count[cba_pkg::CNT_W-1:0];
        return g;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, longint val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[24:0];
        if (idx == cba_pkg::CFG_CHUNK) p_chunk = val & 64'h1FFFFFF;
        else p_discard = val & 64'h1FFFFFF;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (grants_due.size() != 0) @(negedge aclk);
        idle_cycles(4);
    endtask

    task automatic send_item(bit act, longint sz);
        if (!quiet && $urandom_range(99) < 16) idle_cycles($urandom_range(1, 6));
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {7'd0, sz[24:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        grants_due.push_back(predict_grant(act, sz));
        items_sent++;
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    function automatic longint rand_size();
        case ($urandom_range(9))
            0: return 0;
            1: return $urandom_range(1, 16);
            2: return 64'd16777216 - $urandom_range(0, 3);
            3: return $urandom & 25'h1FFFFFF;
            4: return $urandom_range(1, 4096);
            5: return $urandom_range(1, 300000);
            default: return $urandom_range(1, 1024);
        endcase
    endfunction

    always @(posedge aclk) begin
        grant_t got, want;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(grant_t)-1:0];
                if (grants_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item %h", got);
                end else begin
                    want = grants_due.pop_front();
                    grants_seen++;
                    if (want.status == cba_pkg::ST_TABLE_FULL) n_full++;
                    if (want.status == cba_pkg::ST_MEM_FULL) n_exh++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp addr=%h g=%b st=%0d tot=%0d fb=%0d ct=%0d cf=%0d",
                                want.addr, want.granted, want.status, want.total, want.freeb,
                                want.ctotal, want.cfree);
                            $display("          got addr=%h g=%b st=%0d tot=%0d fb=%0d ct=%0d cf=%0d",
                                got.addr, got.granted, got.status, got.total, got.freeb,
                                got.ctotal, got.cfree);
                        end
                    end
                end
            end
        end
    end

    always @(negedge aclk)
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 16);

    always @(posedge aclk)
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end

    task automatic test_directed;
        send_item(cba_pkg::ACT_ALLOC, 0);
        send_item(cba_pkg::ACT_ALLOC, 100);
        send_item(cba_pkg::ACT_ALLOC, 1048576 - 200);
        send_item(cba_pkg::ACT_ALLOC, 16777216);
        send_item(cba_pkg::ACT_ALLOC, 2000000);
        send_item(cba_pkg::ACT_RESET, 25'h1FFFFFF);
        send_item(cba_pkg::ACT_ALLOC, 25'h1FFFFFF);
        send_item(cba_pkg::ACT_ALLOC, 64);
        drain();
        write_reg(cba_pkg::CFG_CHUNK, 0);
        write_reg(cba_pkg::CFG_DISCARD, 0);
        send_item(cba_pkg::ACT_ALLOC, 500000);
        drain();
        write_reg(cba_pkg::CFG_CHUNK, 1);
        write_reg(cba_pkg::CFG_DISCARD, 1);
        for (int i = 0; i < 14; i++) send_item(cba_pkg::ACT_ALLOC, i + 1);
        send_item(cba_pkg::ACT_ALLOC, 1000);
        drain();
    endtask

    task automatic test_table_fill;
        write_reg(cba_pkg::CFG_CHUNK, 100);
        write_reg(cba_pkg::CFG_DISCARD, 16777216);
        send_item(cba_pkg::ACT_RESET, 0);
        for (int i = 0; i < 20; i++) send_item(cba_pkg::ACT_ALLOC, $urandom_range(1, 50));
        send_item(cba_pkg::ACT_RESET, 0);
        for (int i = 0; i < 20; i++) send_item(cba_pkg::ACT_ALLOC, $urandom_range(0, 200));
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin write_reg(cba_pkg::CFG_CHUNK, $urandom_range(1, 4096));
                         write_reg(cba_pkg::CFG_DISCARD, $urandom_range(1, 64)); end
                1: begin write_reg(cba_pkg::CFG_CHUNK, 16777216);
                         write_reg(cba_pkg::CFG_DISCARD, $urandom & 25'h1FFFFFF); end
                2: begin write_reg(cba_pkg::CFG_CHUNK, $urandom_range(100000, 2000000));
                         write_reg(cba_pkg::CFG_DISCARD, $urandom_range(1, 2000)); end
                default: begin write_reg(cba_pkg::CFG_CHUNK, $urandom & 25'h1FFFFFF);
                         write_reg(cba_pkg::CFG_DISCARD, 1); end
            endcase
            quiet = (ph == 5);
            for (int i = 0; i < 175; i++) begin
                if ($urandom_range(99) < 5)
                    send_item(cba_pkg::ACT_RESET, $urandom & 25'h1FFFFFF);
                else send_item(cba_pkg::ACT_ALLOC, rand_size());
            end
            quiet = 1'b0;
            drain();
        end
    endtask

    initial begin
        p_chunk = 1048576;
        p_discard = 64;
        c_count = 0; f_count = 0; mem_top = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_fill();
        test_random();
        idle_cycles(100);
        $display("sent %0d items, checked %0d results (%0d table-full, %0d out-of-memory)",
                 items_sent, grants_seen, n_full, n_exh);
        if (mismatches == 0 && grants_due.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
